### src/day_number_date_converter_core_defines.svh
// ----------------------------------------------------------------------------
// day_number_date_converter_core_defines.svh
// assertion macros used by the date converter datapath
// ----------------------------------------------------------------------------
`ifndef DAY_NUMBER_DATE_CONVERTER_CORE_DEFINES_SVH
`define DAY_NUMBER_DATE_CONVERTER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define DNDC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define DNDC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/dndc_pkg.sv
// ----------------------------------------------------------------------------
// dndc_pkg
// types, constants and calendar functions for the day number date converter
// ----------------------------------------------------------------------------
package dndc_pkg;

  // field widths
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DNUM_W  = 22;
  localparam int SECS_W  = 39;
  localparam int DIY_W   = 9;

  // calendar limits
  localparam int MAX_YEAR = 9999;
  localparam int MAX_DAY_NUMBER = 365 * (MAX_YEAR + 1) + (MAX_YEAR + 4) / 4
                                  - (MAX_YEAR + 100) / 100 + (MAX_YEAR + 400) / 400;
  localparam int SECS_PER_DAY = 24 * 60 * 60;

  // modulo counter wrap points for the leap rule
  localparam int CENTURY     = 100;
  localparam int QUAD_CENTURY = 400;

  // conversion kinds
  localparam logic KIND_DATE_TO_NUM = 1'b0;
  localparam logic KIND_NUM_TO_DATE = 1'b1;

  // month codes
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic              kind;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [DNUM_W-1:0]  day_number;
  } req_t;

  typedef struct packed {
    logic              valid_res;
    logic [YEAR_W-1:0]  year_out;
    logic [MONTH_W-1:0] month_out;
    logic [DAY_W-1:0]   day_out;
    logic [DNUM_W-1:0]  day_count_out;
    logic [SECS_W-1:0]  seconds_out;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic year_step;
    logic month_step;
    logic add_day;
    logic scale;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad_input;
    logic to_date;
    logic year_more;
    logic month_more;
    logic out_free;
  } sts_t;

  function automatic logic [DIY_W-1:0] days_in_year(input logic leap);
    days_in_year = leap ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [DAY_W-1:0] days_in_month(input logic leap,
                                                     input logic [MONTH_W-1:0] month);
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days_in_month = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    days_in_month = 5'd30;
      MONTH_FEB:                                  days_in_month = leap ? 5'd29 : 5'd28;
      default:                                    days_in_month = 5'd0;
    endcase
  endfunction

endpackage

### src/dndc_ctrl.sv
// ----------------------------------------------------------------------------
// dndc_ctrl
// sequencer: load, walk years, walk months, add day and scale (date to number only), hand off result
// ----------------------------------------------------------------------------
module dndc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  dndc_pkg::sts_t sts,
  output dndc_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_YEAR  = 3'd1;
  localparam logic [2:0] S_MONTH = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_YEAR;
        end
      end
      S_YEAR: begin
        priority if (sts.bad_input) begin
          state_next = S_DONE;
        end else if (sts.year_more) begin
          cmd.year_step = 1'b1;
        end else begin
          state_next = S_MONTH;
        end
      end
      S_MONTH: begin
        priority if (sts.month_more) begin
          cmd.month_step = 1'b1;
        end else if (sts.to_date) begin
          state_next = S_DONE;
        end else begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_day = 1'b1;
        state_next  = S_MUL;
      end
      S_MUL: begin
        cmd.scale  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/dndc_dp.sv
// ----------------------------------------------------------------------------
// dndc_dp
// year and month walker with running day total, leap counters, output register
// ----------------------------------------------------------------------------
`include "day_number_date_converter_core_defines.svh"

module dndc_dp (
  input  logic           clk,
  input  logic           rst,
  input  dndc_pkg::req_t req,
  input  dndc_pkg::cmd_t cmd,
  output dndc_pkg::sts_t sts,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output dndc_pkg::rsp_t rsp
);

  // latched request
  logic                          kind;
  logic [dndc_pkg::YEAR_W-1:0]   year_in;
  logic [dndc_pkg::MONTH_W-1:0]  month_in;
  logic [dndc_pkg::DAY_W-1:0]    day_in;
  logic                          bad;
  logic                          ok;

  // walk state
  logic [dndc_pkg::YEAR_W-1:0]   y;
  logic [dndc_pkg::MONTH_W-1:0]  m;
  logic [1:0]                    c4;
  logic [6:0]                    c100;
  logic [8:0]                    c400;
  logic [dndc_pkg::DNUM_W-1:0]   acc;
  logic [dndc_pkg::SECS_W-1:0]   secs;

  logic                          leap;
  logic [dndc_pkg::DNUM_W-1:0]   diy;
  logic [dndc_pkg::DNUM_W-1:0]   dim;
  logic                          req_bad;
  dndc_pkg::rsp_t                rsp_next;

  // leap rule from modulo counters tracking y
  assign leap = (c4 == 2'd0) && ((c100 != 7'd0) || (c400 == 9'd0));
  assign diy  = dndc_pkg::DNUM_W'(dndc_pkg::days_in_year(leap));
  assign dim  = dndc_pkg::DNUM_W'(dndc_pkg::days_in_month(leap, m));

  // range checks that need no walking
  always_comb begin
    if (req.kind == dndc_pkg::KIND_NUM_TO_DATE) begin
      req_bad = (req.day_number == '0) ||
                (req.day_number > dndc_pkg::DNUM_W'(dndc_pkg::MAX_DAY_NUMBER));
    end else begin
      req_bad = (req.year > dndc_pkg::YEAR_W'(dndc_pkg::MAX_YEAR)) ||
                (req.month < dndc_pkg::MONTH_JAN) || (req.month > dndc_pkg::MONTH_DEC) ||
                (req.day == '0);
    end
  end

  // status to controller
  always_comb begin
    sts.bad_input = bad;
    sts.to_date   = (kind == dndc_pkg::KIND_NUM_TO_DATE);
    if (kind == dndc_pkg::KIND_NUM_TO_DATE) begin
      sts.year_more  = (acc > diy);
      sts.month_more = (m != dndc_pkg::MONTH_DEC) && (acc > dim);
    end else begin
      sts.year_more  = (y != year_in);
      sts.month_more = (m != month_in);
    end
    sts.out_free = !rsp_valid || rsp_ready;
  end

  // request latch and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind     <= req.kind;
      year_in  <= req.year;
      month_in <= req.month;
      day_in   <= req.day;
      bad      <= req_bad;
      ok       <= 1'b1;
      y        <= '0;
      m        <= dndc_pkg::MONTH_JAN;
      c4       <= '0;
      c100     <= '0;
      c400     <= '0;
      acc      <= (req.kind == dndc_pkg::KIND_NUM_TO_DATE) ? req.day_number : '0;
    end
    // one year per cycle
    if (cmd.year_step) begin
      acc  <= (kind == dndc_pkg::KIND_NUM_TO_DATE) ? acc - diy : acc + diy;
      y    <= y + 1'b1;
      c4   <= c4 + 1'b1;
      c100 <= (c100 == 7'(dndc_pkg::CENTURY - 1)) ? '0 : c100 + 1'b1;
      c400 <= (c400 == 9'(dndc_pkg::QUAD_CENTURY - 1)) ? '0 : c400 + 1'b1;
    end
    // one month per cycle
    if (cmd.month_step) begin
      acc <= (kind == dndc_pkg::KIND_NUM_TO_DATE) ? acc - dim : acc + dim;
      m   <= m + 1'b1;
    end
    // day of month, with its bound check against the target month
    if (cmd.add_day) begin
      acc <= acc + dndc_pkg::DNUM_W'(day_in);
      ok  <= (day_in <= dndc_pkg::days_in_month(leap, month_in));
    end
    if (cmd.scale) begin
      secs <= {{(dndc_pkg::SECS_W-dndc_pkg::DNUM_W){1'b0}}, acc} *
              dndc_pkg::SECS_W'(dndc_pkg::SECS_PER_DAY);
    end
  end

  // response fields, all zero when invalid or unused by the kind
  always_comb begin
    rsp_next = '0;
    if (!bad && ok) begin
      rsp_next.valid_res = 1'b1;
      if (kind == dndc_pkg::KIND_NUM_TO_DATE) begin
        rsp_next.year_out  = y;
        rsp_next.month_out = m;
        rsp_next.day_out   = acc[dndc_pkg::DAY_W-1:0];
      end else begin
        rsp_next.day_count_out = acc;
        rsp_next.seconds_out   = secs;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp <= rsp_next;
    end
  end

  `DNDC_ASSERT_IMP(a_year_bound, cmd.year_step, y < dndc_pkg::YEAR_W'(dndc_pkg::MAX_YEAR), "year walk past limit")
  `DNDC_ASSERT_IMP(a_month_bound, cmd.month_step, m < dndc_pkg::MONTH_DEC, "month walk past december")
  `DNDC_ASSERT_IMP(a_total_bound, cmd.scale, acc <= dndc_pkg::DNUM_W'(dndc_pkg::MAX_DAY_NUMBER), "day total out of range")
  `DNDC_ASSERT_IMP(a_day_nonzero, cmd.emit && !bad && (kind == dndc_pkg::KIND_NUM_TO_DATE), (acc != '0) && (acc <= dim), "day of month out of range")
  `DNDC_ASSERT_NEXT(a_emit_valid, cmd.emit, rsp_valid, "transfer not presented")

endmodule

### src/day_number_date_converter_core.sv
// Date to number: walk years, walk months, add the day, scale to seconds, hand off;
// number to date: walk years and months, hand off. Bad requests go straight to hand off.
// Throughput: one item at a time, set by the year walker at one year per cycle;
// a new request is taken only after the last result has been handed off.
// Reset (rst, synchronous) returns the sequencer to idle and drops rsp_valid.
// ----------------------------------------------------------------------------
// day_number_date_converter_core
// proleptic gregorian date to day number and back, one year or month per cycle
// ----------------------------------------------------------------------------
module day_number_date_converter_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  dndc_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output dndc_pkg::rsp_t rsp
);

  dndc_pkg::cmd_t cmd;
  dndc_pkg::sts_t sts;

  // sequencer
  dndc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // walker and output register
  dndc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
